// File: design/ids_pkg.sv
package ids_pkg;

  localparam int CHAN_W  = 8;
  localparam int SIZE_W  = 13;
  localparam int CFG_W   = 13;
  localparam int INDEX_W = 2;
  localparam int COUNT_W = 25;
  localparam int DSUM_W  = 32;
  localparam int CSUM_W  = 36;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [INDEX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [INDEX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [INDEX_W-1:0] REG_HEIGHT    = 2'd2;

  localparam logic [CFG_W-1:0] SIZE_RESET = 13'd4096;

  typedef logic [CHAN_W-1:0] chan_t;

endpackage

// File: design/ids_pixel_delta.sv
module ids_pixel_delta (
  input  ids_pkg::chan_t red_first,
  input  ids_pkg::chan_t green_first,
  input  ids_pkg::chan_t blue_first,
  input  ids_pkg::chan_t red_second,
  input  ids_pkg::chan_t green_second,
  input  ids_pkg::chan_t blue_second,
  input  ids_pkg::chan_t threshold,
  output ids_pkg::chan_t delta,
  output logic           differs
);
  import ids_pkg::*;

  chan_t red_diff;
  chan_t green_diff;
  chan_t blue_diff;
  chan_t rg_max;

  assign red_diff   = (red_first > red_second) ? red_first - red_second
                                               : red_second - red_first;
  assign green_diff = (green_first > green_second) ? green_first - green_second
                                                   : green_second - green_first;
  assign blue_diff  = (blue_first > blue_second) ? blue_first - blue_second
                                                 : blue_second - blue_first;

  assign rg_max  = (green_diff > red_diff) ? green_diff : red_diff;
  assign delta   = (blue_diff > rg_max) ? blue_diff : rg_max;
  assign differs = delta > threshold;

endmodule

// File: design/image_difference_statistics_top.sv
// Channel  | Direction | Handshake                   | Content
// pixel    | in        | pixel_valid / pixel_ready   | RGB pair, one pixel of each image
// result   | out       | result_valid / result_ready | frame totals and bounding box
// config   | in        | cfg_we                      | cfg_index selects, cfg_data value
//
// One pixel pair per cycle while no waiting result holds the last pixel; delta,
// compare and all accumulator updates feed both statistics and result registers.
// The frame result appears in the cycle after its last pixel is taken.
// A stalled result blocks only the last pixel of the next frame; other pixels flow on.
// rst (synchronous) clears position, accumulators and result valid, and resets config.
module image_difference_statistics_top #(
  parameter int MAX_WIDTH  = ids_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ids_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         cfg_we,
  input  logic [ids_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [ids_pkg::CFG_W-1:0]    cfg_data,

  input  logic                         pixel_valid,
  output logic                         pixel_ready,
  input  ids_pkg::chan_t               red_first,
  input  ids_pkg::chan_t               green_first,
  input  ids_pkg::chan_t               blue_first,
  input  ids_pkg::chan_t               red_second,
  input  ids_pkg::chan_t               green_second,
  input  ids_pkg::chan_t               blue_second,

  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [ids_pkg::COUNT_W-1:0]  differing_pixels,
  output logic [ids_pkg::DSUM_W-1:0]   delta_total,
  output ids_pkg::chan_t               delta_peak,
  output logic [ids_pkg::SIZE_W-1:0]   box_left,
  output logic signed [ids_pkg::SIZE_W-1:0] box_right,
  output logic [ids_pkg::SIZE_W-1:0]   box_bottom,
  output logic signed [ids_pkg::SIZE_W-1:0] box_top,
  output logic [ids_pkg::CSUM_W-1:0]   column_sum,
  output logic [ids_pkg::CSUM_W-1:0]   row_sum
);
  import ids_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [DSUM_W-1:0]  DSUM_MAX  = '1;
  localparam logic [CSUM_W-1:0]  CSUM_MAX  = '1;

  function automatic logic [31:0] eff_size(logic [CFG_W-1:0] v, logic [31:0] maxv);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide == 32'd0) begin
      return 32'd1;
    end else if (wide > maxv) begin
      return maxv;
    end
    return wide;
  endfunction

  // Configuration
  chan_t            threshold;
  logic [CFG_W-1:0] width_cfg;
  logic [CFG_W-1:0] height_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= '0;
      width_cfg  <= SIZE_RESET;
      height_cfg <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold  <= cfg_data[CHAN_W-1:0];
        REG_WIDTH:     width_cfg  <= cfg_data;
        REG_HEIGHT:    height_cfg <= cfg_data;
        default:       ;
      endcase
    end
  end

  logic [31:0] eff_w;
  logic [31:0] eff_h;

  assign eff_w = eff_size(width_cfg, 32'(MAX_WIDTH));
  assign eff_h = eff_size(height_cfg, 32'(MAX_HEIGHT));

  // Frame statistics
  logic [COL_W-1:0]   column_pos;
  logic [ROW_W-1:0]   row_pos;
  logic [COUNT_W-1:0] count_acc;
  logic [DSUM_W-1:0]  delta_acc;
  chan_t              peak_reg;
  logic [COL_W-1:0]   left_reg;
  logic [COL_W-1:0]   right_reg;
  logic [ROW_W-1:0]   bottom_reg;
  logic [ROW_W-1:0]   top_reg;
  logic [CSUM_W-1:0]  colsum_acc;
  logic [CSUM_W-1:0]  rowsum_acc;

  chan_t delta;
  logic  differs;

  ids_pixel_delta u_delta (
    .red_first    (red_first),
    .green_first  (green_first),
    .blue_first   (blue_first),
    .red_second   (red_second),
    .green_second (green_second),
    .blue_second  (blue_second),
    .threshold    (threshold),
    .delta        (delta),
    .differs      (differs)
  );

  logic last_col;
  logic last_row;
  logic last_pixel;
  logic accept;
  logic first_hit;

  assign last_col   = 32'(column_pos) >= (eff_w - 32'd1);
  assign last_row   = 32'(row_pos) >= (eff_h - 32'd1);
  assign last_pixel = last_col && last_row;
  // Hold only the final pixel of a frame while an earlier result is still waiting.
  assign pixel_ready = !last_pixel || !result_valid || result_ready;
  assign accept      = pixel_valid && pixel_ready;
  assign first_hit   = count_acc == '0;

  logic [COUNT_W-1:0] count_next;
  logic [DSUM_W:0]    delta_sum;
  logic [DSUM_W-1:0]  delta_next;
  chan_t              peak_next;
  logic [COL_W-1:0]   left_next;
  logic [COL_W-1:0]   right_next;
  logic [ROW_W-1:0]   bottom_next;
  logic [ROW_W-1:0]   top_next;
  logic [CSUM_W:0]    colsum_sum;
  logic [CSUM_W:0]    rowsum_sum;
  logic [CSUM_W-1:0]  colsum_next;
  logic [CSUM_W-1:0]  rowsum_next;

  assign delta_sum  = {1'b0, delta_acc} + (DSUM_W + 1)'(delta);
  assign colsum_sum = {1'b0, colsum_acc} + (CSUM_W + 1)'(column_pos);
  assign rowsum_sum = {1'b0, rowsum_acc} + (CSUM_W + 1)'(row_pos);

  always_comb begin
    count_next  = count_acc;
    delta_next  = delta_acc;
    peak_next   = peak_reg;
    left_next   = left_reg;
    right_next  = right_reg;
    bottom_next = bottom_reg;
    top_next    = top_reg;
    colsum_next = colsum_acc;
    rowsum_next = rowsum_acc;
    if (differs) begin
      count_next  = (count_acc == COUNT_MAX) ? COUNT_MAX : count_acc + COUNT_W'(1);
      delta_next  = delta_sum[DSUM_W] ? DSUM_MAX : delta_sum[DSUM_W-1:0];
      colsum_next = colsum_sum[CSUM_W] ? CSUM_MAX : colsum_sum[CSUM_W-1:0];
      rowsum_next = rowsum_sum[CSUM_W] ? CSUM_MAX : rowsum_sum[CSUM_W-1:0];
      if (delta > peak_reg) begin
        peak_next = delta;
      end
      if (first_hit || column_pos < left_reg) begin
        left_next = column_pos;
      end
      if (first_hit || column_pos > right_reg) begin
        right_next = column_pos;
      end
      if (first_hit || row_pos < bottom_reg) begin
        bottom_next = row_pos;
      end
      if (first_hit || row_pos > top_reg) begin
        top_next = row_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
      count_acc  <= '0;
      delta_acc  <= '0;
      peak_reg   <= '0;
      colsum_acc <= '0;
      rowsum_acc <= '0;
    end else if (accept) begin
      if (last_pixel) begin
        column_pos <= '0;
        row_pos    <= '0;
        count_acc  <= '0;
        delta_acc  <= '0;
        peak_reg   <= '0;
        colsum_acc <= '0;
        rowsum_acc <= '0;
      end else begin
        if (last_col) begin
          column_pos <= '0;
          row_pos    <= row_pos + ROW_W'(1);
        end else begin
          column_pos <= column_pos + COL_W'(1);
        end
        count_acc  <= count_next;
        delta_acc  <= delta_next;
        peak_reg   <= peak_next;
        colsum_acc <= colsum_next;
        rowsum_acc <= rowsum_next;
      end
    end
  end

  // Box extremes are only read once count_acc is non-zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      left_reg   <= left_next;
      right_reg  <= right_next;
      bottom_reg <= bottom_next;
      top_reg    <= top_next;
    end
  end

  // Result register
  logic [31:0] left_wide;
  logic [31:0] right_wide;
  logic [31:0] bottom_wide;
  logic [31:0] top_wide;
  logic        any_hit;

  assign left_wide   = 32'(left_next);
  assign right_wide  = 32'(right_next);
  assign bottom_wide = 32'(bottom_next);
  assign top_wide    = 32'(top_next);
  assign any_hit     = count_next != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && last_pixel) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_pixel) begin
      differing_pixels <= count_next;
      delta_total      <= delta_next;
      delta_peak       <= peak_next;
      column_sum       <= colsum_next;
      row_sum          <= rowsum_next;
      if (any_hit) begin
        box_left   <= left_wide[SIZE_W-1:0];
        box_right  <= right_wide[SIZE_W-1:0];
        box_bottom <= bottom_wide[SIZE_W-1:0];
        box_top    <= top_wide[SIZE_W-1:0];
      end else begin
        box_left   <= eff_w[SIZE_W-1:0];
        box_right  <= '1;
        box_bottom <= eff_h[SIZE_W-1:0];
        box_top    <= '1;
      end
    end
  end

endmodule

// File: tb/sv/diff_stats_monitor.sv
module diff_stats_monitor #(
  parameter int MAX_WIDTH  = ids_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ids_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         cfg_we,
  input  logic [ids_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [ids_pkg::CFG_W-1:0]    cfg_data,

  input  logic                         pixel_valid,
  input  logic                         pixel_ready,
  input  ids_pkg::chan_t               red_first,
  input  ids_pkg::chan_t               green_first,
  input  ids_pkg::chan_t               blue_first,
  input  ids_pkg::chan_t               red_second,
  input  ids_pkg::chan_t               green_second,
  input  ids_pkg::chan_t               blue_second,

  input  logic                         result_valid,
  input  logic                         result_ready,
  input  logic [ids_pkg::COUNT_W-1:0]  differing_pixels,
  input  logic [ids_pkg::DSUM_W-1:0]   delta_total,
  input  ids_pkg::chan_t               delta_peak,
  input  logic [ids_pkg::SIZE_W-1:0]   box_left,
  input  logic [ids_pkg::SIZE_W-1:0]   box_right,
  input  logic [ids_pkg::SIZE_W-1:0]   box_bottom,
  input  logic [ids_pkg::SIZE_W-1:0]   box_top,
  input  logic [ids_pkg::CSUM_W-1:0]   column_sum,
  input  logic [ids_pkg::CSUM_W-1:0]   row_sum,

  output int                           fail_count,
  output int                           frames_checked,
  output int                           backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  import ids_pkg::*;

  localparam longint unsigned COUNT_CEIL = (64'd1 << COUNT_W) - 1;
  localparam longint unsigned DSUM_CEIL  = (64'd1 << DSUM_W) - 1;
  localparam longint unsigned CSUM_CEIL  = (64'd1 << CSUM_W) - 1;

  typedef struct packed {
    logic [COUNT_W-1:0] pixels;
    logic [DSUM_W-1:0]  delta_sum;
    chan_t              peak;
    logic [SIZE_W-1:0]  col_lo;
    logic [SIZE_W-1:0]  col_hi;
    logic [SIZE_W-1:0]  row_lo;
    logic [SIZE_W-1:0]  row_hi;
    logic [CSUM_W-1:0]  col_sum;
    logic [CSUM_W-1:0]  row_sum;
  } frame_totals_t;

  frame_totals_t pending_totals[$];

  chan_t             thr_q;
  logic [CFG_W-1:0]  width_q;
  logic [CFG_W-1:0]  height_q;

  int                cur_col;
  int                cur_row;
  longint unsigned   hits;
  longint unsigned   delta_acc;
  longint unsigned   col_acc;
  longint unsigned   row_acc;
  int                peak_delta;
  int                edge_l;
  int                edge_r;
  int                edge_b;
  int                edge_t;

  function automatic int clamp_size(logic [CFG_W-1:0] v, int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function automatic int chan_gap(chan_t a, chan_t b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                              longint unsigned ceiling);
    return (a + b > ceiling) ? ceiling : a + b;
  endfunction

  task automatic start_frame();
    cur_col    = 0;
    cur_row    = 0;
    hits       = 0;
    delta_acc  = 0;
    col_acc    = 0;
    row_acc    = 0;
    peak_delta = 0;
    edge_l     = clamp_size(width_q, MAX_WIDTH);
    edge_r     = -1;
    edge_b     = clamp_size(height_q, MAX_HEIGHT);
    edge_t     = -1;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic accumulate_pixel();
    int w;
    int h;
    int d;
    frame_totals_t t;
    w = clamp_size(width_q, MAX_WIDTH);
    h = clamp_size(height_q, MAX_HEIGHT);
    d = chan_gap(red_first, red_second);
    if (chan_gap(green_first, green_second) > d) d = chan_gap(green_first, green_second);
    if (chan_gap(blue_first, blue_second) > d) d = chan_gap(blue_first, blue_second);

    if (d > int'(thr_q)) begin
      hits      = sat_add(hits, 1, COUNT_CEIL);
      delta_acc = sat_add(delta_acc, d, DSUM_CEIL);
      if (d > peak_delta) peak_delta = d;
      if (hits == 1 || cur_col < edge_l) edge_l = cur_col;
      if (hits == 1 || cur_col > edge_r) edge_r = cur_col;
      if (hits == 1 || cur_row < edge_b) edge_b = cur_row;
      if (hits == 1 || cur_row > edge_t) edge_t = cur_row;
      col_acc = sat_add(col_acc, cur_col, CSUM_CEIL);
      row_acc = sat_add(row_acc, cur_row, CSUM_CEIL);
    end

    // a shrunken size can leave the position past the new last column or row
    if (cur_col < w - 1) begin
      cur_col++;
    end else if (cur_row < h - 1) begin
      cur_col = 0;
      cur_row++;
    end else begin
      t.pixels    = COUNT_W'(hits);
      t.delta_sum = DSUM_W'(delta_acc);
      t.peak      = CHAN_W'(peak_delta);
      t.col_sum   = CSUM_W'(col_acc);
      t.row_sum   = CSUM_W'(row_acc);
      if (hits != 0) begin
        t.col_lo = SIZE_W'(edge_l);
        t.col_hi = SIZE_W'(edge_r);
        t.row_lo = SIZE_W'(edge_b);
        t.row_hi = SIZE_W'(edge_t);
      end else begin
        // empty box: report the size in force now, not at frame start
        t.col_lo = SIZE_W'(w);
        t.col_hi = '1;
        t.row_lo = SIZE_W'(h);
        t.row_hi = '1;
      end
      pending_totals.push_back(t);
      start_frame();
    end
  endtask

  task automatic check_totals();
    frame_totals_t want;
    if (pending_totals.size() == 0) begin
      report_mismatch("result request with no frame outstanding");
      return;
    end
    want = pending_totals.pop_front();
    compare_field("differing_pixels", differing_pixels, want.pixels);
    compare_field("delta_total", delta_total, want.delta_sum);
    compare_field("delta_peak", delta_peak, want.peak);
    compare_field("box_left", box_left, want.col_lo);
    compare_field("box_right", box_right, want.col_hi);
    compare_field("box_bottom", box_bottom, want.row_lo);
    compare_field("box_top", box_top, want.row_hi);
    compare_field("column_sum", column_sum, want.col_sum);
    compare_field("row_sum", row_sum, want.row_sum);
    frames_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thr_q    = '0;
      width_q  = SIZE_RESET;
      height_q = SIZE_RESET;
      start_frame();
      pending_totals.delete();
      fail_count     = 0;
      frames_checked = 0;
    end else begin
      // retire before predicting: a frame's result never leaves in its own cycle
      if (result_valid && result_ready) check_totals();
      // a request taken at the writing edge still sees the old settings
      if (pixel_valid && pixel_ready) accumulate_pixel();
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: thr_q    = cfg_data[CHAN_W-1:0];
          REG_WIDTH:     width_q  = cfg_data;
          REG_HEIGHT:    height_q = cfg_data;
          default: ;
        endcase
      end
    end
    backlog = pending_totals.size();
  end

endmodule

// File: tb/sv/tb_image_difference_statistics_top.sv
module tb_image_difference_statistics_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ids_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PIXELS = 400;
  localparam int MIN_FRAMES    = 48;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int EDGE_PIXELS   = 40;

  // index with no register behind it
  localparam logic [INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    chan_t red_a;
    chan_t green_a;
    chan_t blue_a;
    chan_t red_b;
    chan_t green_b;
    chan_t blue_b;
  } pixel_pair_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  logic [INDEX_W-1:0]          cfg_index;
  logic [CFG_W-1:0]            cfg_data;
  logic                        pixel_valid;
  logic                        pixel_ready;
  chan_t                       red_first;
  chan_t                       green_first;
  chan_t                       blue_first;
  chan_t                       red_second;
  chan_t                       green_second;
  chan_t                       blue_second;
  logic                        result_valid;
  logic                        result_ready;
  logic [COUNT_W-1:0]          differing_pixels;
  logic [DSUM_W-1:0]           delta_total;
  chan_t                       delta_peak;
  logic [SIZE_W-1:0]           box_left;
  logic signed [SIZE_W-1:0]    box_right;
  logic [SIZE_W-1:0]           box_bottom;
  logic signed [SIZE_W-1:0]    box_top;
  logic [CSUM_W-1:0]           column_sum;
  logic [CSUM_W-1:0]           row_sum;

  int                          fail_count;
  int                          frames_checked;
  int                          backlog;

  bit                          tx_gaps;
  bit                          rx_gaps;
  bit                          hold_results;
  int unsigned                 pixels_sent;
  int unsigned                 cycle_count = 0;

  image_difference_statistics_top u_dut (.*);

  diff_stats_monitor u_monitor (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        // hold off long enough for the pixel side to back up
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
        result_ready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  function automatic pixel_pair_t random_pixel();
    pixel_pair_t p;
    p[47:32] = 16'($urandom);
    p[31:0]  = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: {p.red_b, p.green_b, p.blue_b} = {p.red_a, p.green_a, p.blue_a};
      4, 5, 6: begin
        {p.red_b, p.green_b, p.blue_b} = {p.red_a, p.green_a, p.blue_a};
        case ($urandom_range(0, 2))
          0:       p.red_b   = p.red_a + chan_t'($urandom_range(0, 6)) - 8'd3;
          1:       p.green_b = p.green_a + chan_t'($urandom_range(0, 6)) - 8'd3;
          default: p.blue_b  = p.blue_a + chan_t'($urandom_range(0, 6)) - 8'd3;
        endcase
      end
      7, 8: ;
      default: begin
        case ($urandom_range(0, 2))
          0: begin
            p.red_a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.red_b = ~p.red_a;
          end
          1: begin
            p.green_a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.green_b = ~p.green_a;
          end
          default: begin
            p.blue_a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.blue_b = ~p.blue_a;
          end
        endcase
      end
    endcase
    return p;
  endfunction

  // Called and returns at a falling edge; valid stays high for the next request.
  task automatic send_pixel(input pixel_pair_t p);
    if (tx_gaps && $urandom_range(0, 9) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    {red_first, green_first, blue_first, red_second, green_second, blue_second} <= p;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic drain_results();
    pixel_valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] w,
                              input logic [CFG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= thr;
    @(negedge clk);
    cfg_index <= REG_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned      phase;
    int unsigned      frame_px;
    int unsigned      burst;
    logic [CFG_W-1:0] thr_pick;
    logic [CFG_W-1:0] w_pick;
    logic [CFG_W-1:0] h_pick;

    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    pixel_valid  = 1'b0;
    {red_first, green_first, blue_first, red_second, green_second, blue_second} = '0;
    tx_gaps      = 1'b0;
    rx_gaps      = 1'b0;
    hold_results = 1'b0;
    pixels_sent  = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // reset settings: threshold 0 on a full-size frame
    send_pixel({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel({8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel({8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
    drain_results();
    // narrow the row under the running position: column 3 now ends the frame
    program_regs(13'd0, 13'd4, 13'd1);
    send_pixel({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255});
    drain_results();

    // threshold 255 with upper bits set: nothing can differ, box stays empty
    program_regs(13'h1FFF, 13'd2, 13'd2);
    send_pixel({8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel({8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255});
    send_pixel({8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0});
    send_pixel({8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255});
    drain_results();

    program_regs(13'd254, 13'd3, 13'd2);
    send_pixel({8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel({8'd10, 8'd200, 8'd30, 8'd20, 8'd0, 8'd31});
    send_pixel({8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd255});
    send_pixel({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0});
    send_pixel({8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128});
    send_pixel({8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0});
    drain_results();

    // write to the unused index, then zero sizes (act as 1 x 1)
    cfg_we    <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_data  <= 13'h1FFF;
    @(negedge clk);
    program_regs(13'd0, 13'd0, 13'd0);
    send_pixel({8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77});
    send_pixel({8'd0, 8'd0, 8'd3, 8'd0, 8'd0, 8'd4});
    drain_results();

    pixels_sent = 0;
    phase = 0;
    while (pixels_sent < RANDOM_PIXELS || frames_checked < MIN_FRAMES) begin
      thr_pick = CFG_W'($urandom_range(0, 8191));
      if ($urandom_range(0, 1)) thr_pick[CHAN_W-1:0] = CHAN_W'($urandom_range(0, 6));
      if ($urandom_range(0, 9) == 0)
        w_pick = 13'd0;
      else if ($urandom_range(0, 3) == 0)
        w_pick = CFG_W'($urandom_range(7, 12));
      else
        w_pick = CFG_W'($urandom_range(1, 6));
      h_pick = CFG_W'($urandom_range(0, 4));
      program_regs(thr_pick, w_pick, h_pick);
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;

      frame_px = (w_pick == 0 ? 1 : w_pick) * (h_pick == 0 ? 1 : h_pick);
      burst = frame_px * $urandom_range(1, 3);
      // leave a frame part-done so the next settings land mid-frame
      if ($urandom_range(0, 3) == 0) burst += $urandom_range(1, frame_px);
      if (phase == 2 || phase == 9) begin
        // two frames end inside the hold, so the second one stalls the input
        hold_results = 1'b1;
        tx_gaps = 1'b0;
        burst += 2 * frame_px;
      end
      repeat (burst) send_pixel(random_pixel());
      drain_results();
      phase++;
    end

    // size extremes, no idling from here on
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    // flush any part-done frame with a 1 x 1 size
    program_regs(13'd0, 13'd1, 13'd1);
    send_pixel(random_pixel());
    drain_results();

    // oversize width acts as the maximum: no row ends early
    program_regs(13'h0C3, 13'h1FFF, 13'd1);
    repeat (EDGE_PIXELS) send_pixel(random_pixel());
    drain_results();
    program_regs(13'h0C3, 13'd1, 13'd1);
    send_pixel(random_pixel());
    drain_results();

    // oversize height acts as the maximum: no frame ends early
    program_regs(13'd0, 13'd1, 13'h1FFF);
    repeat (EDGE_PIXELS) send_pixel(random_pixel());
    drain_results();
    program_regs(13'd0, 13'd1, 13'd1);
    send_pixel(random_pixel());
    drain_results();

    program_regs(13'h1FFF, 13'd4096, 13'd4096);
    repeat (EDGE_PIXELS) send_pixel(random_pixel());
    drain_results();
    program_regs(13'h1FFF, 13'd0, 13'd0);
    send_pixel(random_pixel());
    drain_results();

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: image_difference_statistics_top.f
design/ids_pkg.sv
design/ids_pixel_delta.sv
design/image_difference_statistics_top.sv
tb/sv/diff_stats_monitor.sv
tb/sv/tb_image_difference_statistics_top.sv
